>>> rtl/core/sqll_pkg.sv
// Shared types, token kinds, keyword table and character helpers for the SQL token lexer.
package sqll_pkg;

  localparam int POS_BITS  = 16;
  localparam int LEN_BITS  = 8;
  localparam int KIND_BITS = 6;
  localparam int KW_BYTES  = 8;
  localparam int KW_BITS   = KW_BYTES * 8;
  localparam int KW_COUNT  = 31;

  localparam logic [LEN_BITS-1:0] MAX_TOKEN_LEN = 8'd255;

  // Output queue sizing: two slots must be free before an item is taken.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = 2;
  localparam int CNT_BITS   = 3;

  typedef logic [KIND_BITS-1:0] kind_t;

  localparam kind_t KIND_END    = 6'd0;
  localparam kind_t KIND_IDENT  = 6'd1;
  localparam kind_t KIND_STRING = 6'd2;
  localparam kind_t KIND_NUMBER = 6'd3;
  localparam kind_t KIND_STAR   = 6'd4;
  localparam kind_t KIND_COMMA  = 6'd5;
  localparam kind_t KIND_DOT    = 6'd6;
  localparam kind_t KIND_LPAREN = 6'd7;
  localparam kind_t KIND_RPAREN = 6'd8;
  localparam kind_t KIND_EQ     = 6'd9;
  localparam kind_t KIND_SEMI   = 6'd10;
  localparam kind_t KIND_NEQ    = 6'd11;
  localparam kind_t KIND_LT     = 6'd12;
  localparam kind_t KIND_GT     = 6'd13;
  localparam kind_t KIND_LTE    = 6'd14;
  localparam kind_t KIND_GTE    = 6'd15;
  localparam kind_t KIND_ERROR  = 6'd16;
  localparam kind_t KIND_KW0    = 6'd17;

  typedef struct packed {
    kind_t               kind;
    logic [POS_BITS-1:0] start_pos;
    logic [LEN_BITS-1:0] length;
    logic                last_of_run;
  } token_t;

  // Tokens produced by one accepted item, in output order.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } step_t;

  // Keyword text, right-justified and zero padded on the left.
  localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    "SELECT", "FROM", "WHERE", "AND", "OR", "NOT", "ORDER", "BY", "ASC",
    "DESC", "JOIN", "ON", "INNER", "LEFT", "INSERT", "INTO", "VALUES",
    "COUNT", "SUM", "AVG", "MIN", "MAX", "AS", "LIMIT", "GROUP", "HAVING",
    "LIKE", "IN", "IS", "NULL", "DISTINCT"
  };

  // Repack keyword text so the first character sits in the low byte,
  // matching the layout of the identifier buffer.
  function automatic logic [KW_BITS-1:0] kw_pack(input logic [KW_BITS-1:0] s);
    logic [KW_BITS-1:0] r;
    logic [3:0]         n;
    r = '0;
    n = '0;
    for (int i = KW_BYTES - 1; i >= 0; i--) begin
      if (s[8*i +: 8] != 8'h00) begin
        r[{n[2:0], 3'b000} +: 8] = s[8*i +: 8];
        n = n + 4'd1;
      end
    end
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) ? (c - 8'd32) : c;
  endfunction

endpackage

>>> rtl/core/sqll_in_if.sv
// Input channel: one text byte or an end marker per item.
interface sqll_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_end;

  modport source (output valid, ch, is_end, input ready);
  modport sink   (input valid, ch, is_end, output ready);
endinterface

>>> rtl/core/sqll_out_if.sv
// Output channel: one token per item.
interface sqll_out_if;
  logic                          valid;
  logic                          ready;
  logic [sqll_pkg::KIND_BITS-1:0] kind;
  logic [sqll_pkg::POS_BITS-1:0]  start_pos;
  logic [sqll_pkg::LEN_BITS-1:0]  length;
  logic                          last_of_run;

  modport source (output valid, kind, start_pos, length, last_of_run, input ready);
  modport sink   (input valid, kind, start_pos, length, last_of_run, output ready);
endinterface

>>> rtl/core/sqll_kw_match.sv
// Parallel compare of the identifier buffer against the keyword table.
module sqll_kw_match (
  input  logic [sqll_pkg::KW_BITS-1:0] kw_buf,
  input  logic                         too_long,
  output sqll_pkg::kind_t              kind
);

  // Keywords are distinct, so at most one compare hits.
  always_comb begin
    kind = sqll_pkg::KIND_IDENT;
    if (!too_long) begin
      for (int k = 0; k < sqll_pkg::KW_COUNT; k++) begin
        if (kw_buf == sqll_pkg::kw_pack(sqll_pkg::KW_TEXT[k])) begin
          kind = sqll_pkg::KIND_KW0 + sqll_pkg::KIND_BITS'(k);
        end
      end
    end
  end

endmodule

>>> rtl/core/sqll_scan.sv
// Lexer state machine: one byte per cycle, up to two tokens per item.
module sqll_scan (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      ch,
  input  logic            is_end,
  output sqll_pkg::step_t step
);

  typedef enum logic [3:0] {
    M_IDLE, M_LT, M_GT, M_BANG, M_MINUS, M_STR, M_STR_ESC, M_INT, M_FRAC, M_IDENT
  } mode_t;

  mode_t                          mode, mode_next;
  logic [sqll_pkg::POS_BITS-1:0]  position, position_next;
  logic [sqll_pkg::POS_BITS-1:0]  token_start, token_start_next;
  logic [sqll_pkg::KW_BITS-1:0]   kw_buf, kw_buf_next;
  logic                           too_long, too_long_next;
  logic [sqll_pkg::LEN_BITS-1:0]  tok_len, tok_len_next;

  logic [sqll_pkg::LEN_BITS-1:0]  len_bump;
  sqll_pkg::kind_t                ident_kind;
  logic                           taken;
  logic                           flush_valid, idle_valid, tk_valid;
  sqll_pkg::token_t               flush_tok, idle_tok, tk_tok, end_tok;
  logic                           a_valid, b_valid;
  sqll_pkg::token_t               a_tok, b_tok;
  logic [7:0]                     up_ch;

  sqll_kw_match u_kw (
    .kw_buf   (kw_buf),
    .too_long (too_long),
    .kind     (ident_kind)
  );

  assign len_bump = (tok_len < sqll_pkg::MAX_TOKEN_LEN) ?
                    (tok_len + sqll_pkg::LEN_BITS'(1)) : tok_len;
  assign up_ch    = sqll_pkg::to_upper(ch);

  // Pending token emitted when the current byte does not extend it
  always_comb begin
    flush_valid         = 1'b1;
    flush_tok           = '0;
    flush_tok.start_pos = token_start;
    flush_tok.length    = sqll_pkg::LEN_BITS'(1);
    case (mode)
      M_LT:      flush_tok.kind = sqll_pkg::KIND_LT;
      M_GT:      flush_tok.kind = sqll_pkg::KIND_GT;
      M_BANG,
      M_MINUS:   flush_tok.kind = sqll_pkg::KIND_ERROR;
      M_STR,
      M_STR_ESC: begin
        flush_tok.kind   = sqll_pkg::KIND_STRING;
        flush_tok.length = tok_len;
      end
      M_INT,
      M_FRAC: begin
        flush_tok.kind   = sqll_pkg::KIND_NUMBER;
        flush_tok.length = tok_len;
      end
      M_IDENT: begin
        flush_tok.kind   = ident_kind;
        flush_tok.length = tok_len;
      end
      default: flush_valid = 1'b0;
    endcase
  end

  // Single-byte tokens started from idle
  always_comb begin
    idle_valid         = 1'b1;
    idle_tok           = '0;
    idle_tok.start_pos = position;
    idle_tok.length    = sqll_pkg::LEN_BITS'(1);
    case (ch)
      "*":     idle_tok.kind = sqll_pkg::KIND_STAR;
      ",":     idle_tok.kind = sqll_pkg::KIND_COMMA;
      ".":     idle_tok.kind = sqll_pkg::KIND_DOT;
      "(":     idle_tok.kind = sqll_pkg::KIND_LPAREN;
      ")":     idle_tok.kind = sqll_pkg::KIND_RPAREN;
      "=":     idle_tok.kind = sqll_pkg::KIND_EQ;
      ";":     idle_tok.kind = sqll_pkg::KIND_SEMI;
      "<", ">", "!", "-", "'": idle_valid = 1'b0;
      default: begin
        idle_tok.kind = sqll_pkg::KIND_ERROR;
        if (sqll_pkg::is_space(ch) || sqll_pkg::is_word(ch)) begin
          idle_valid = 1'b0;
        end
      end
    endcase
  end

  // Mode transitions and state updates
  always_comb begin
    mode_next        = mode;
    position_next    = position + sqll_pkg::POS_BITS'(1);
    token_start_next = token_start;
    kw_buf_next      = kw_buf;
    too_long_next    = too_long;
    tok_len_next     = tok_len;
    taken            = 1'b0;
    tk_valid         = 1'b0;
    tk_tok           = '0;
    tk_tok.start_pos = token_start;
    tk_tok.length    = sqll_pkg::LEN_BITS'(2);

    case (mode)
      M_LT: begin
        if ((ch == ">") || (ch == "=")) begin
          tk_valid    = 1'b1;
          tk_tok.kind = (ch == ">") ? sqll_pkg::KIND_NEQ : sqll_pkg::KIND_LTE;
          mode_next   = M_IDLE;
          taken       = 1'b1;
        end
      end
      M_GT: begin
        if (ch == "=") begin
          tk_valid    = 1'b1;
          tk_tok.kind = sqll_pkg::KIND_GTE;
          mode_next   = M_IDLE;
          taken       = 1'b1;
        end
      end
      M_BANG: begin
        if (ch == "=") begin
          tk_valid    = 1'b1;
          tk_tok.kind = sqll_pkg::KIND_NEQ;
          mode_next   = M_IDLE;
          taken       = 1'b1;
        end
      end
      M_MINUS: begin
        if (sqll_pkg::is_digit(ch)) begin
          mode_next    = M_INT;
          tok_len_next = len_bump;
          taken        = 1'b1;
        end
      end
      M_STR: begin
        taken = 1'b1;
        if (ch == "'") begin
          tk_valid      = 1'b1;
          tk_tok.kind   = sqll_pkg::KIND_STRING;
          tk_tok.length = tok_len;
          mode_next     = M_IDLE;
        end else begin
          tok_len_next = len_bump;
          if (ch == "\\") begin
            mode_next = M_STR_ESC;
          end
        end
      end
      M_STR_ESC: begin
        tok_len_next = len_bump;
        mode_next    = M_STR;
        taken        = 1'b1;
      end
      M_INT: begin
        if (sqll_pkg::is_digit(ch) || (ch == ".")) begin
          tok_len_next = len_bump;
          taken        = 1'b1;
          if (ch == ".") begin
            mode_next = M_FRAC;
          end
        end
      end
      M_FRAC: begin
        if (sqll_pkg::is_digit(ch)) begin
          tok_len_next = len_bump;
          taken        = 1'b1;
        end
      end
      M_IDENT: begin
        if (sqll_pkg::is_word(ch)) begin
          if (tok_len < sqll_pkg::LEN_BITS'(sqll_pkg::KW_BYTES)) begin
            for (int i = 0; i < sqll_pkg::KW_BYTES; i++) begin
              if (tok_len[2:0] == 3'(i)) begin
                kw_buf_next[8*i +: 8] = up_ch;
              end
            end
          end else begin
            too_long_next = 1'b1;
          end
          tok_len_next = len_bump;
          taken        = 1'b1;
        end
      end
      default: ;
    endcase

    // Byte not absorbed: lex it from idle, possibly starting a new token
    if (!taken) begin
      mode_next = M_IDLE;
      case (ch)
        "<": begin
          mode_next        = M_LT;
          token_start_next = position;
          tok_len_next     = sqll_pkg::LEN_BITS'(1);
        end
        ">": begin
          mode_next        = M_GT;
          token_start_next = position;
          tok_len_next     = sqll_pkg::LEN_BITS'(1);
        end
        "!": begin
          mode_next        = M_BANG;
          token_start_next = position;
          tok_len_next     = sqll_pkg::LEN_BITS'(1);
        end
        "-": begin
          mode_next        = M_MINUS;
          token_start_next = position;
          tok_len_next     = sqll_pkg::LEN_BITS'(1);
        end
        "'": begin
          mode_next        = M_STR;
          token_start_next = position + sqll_pkg::POS_BITS'(1);
          tok_len_next     = '0;
        end
        default: begin
          if (sqll_pkg::is_digit(ch)) begin
            mode_next        = M_INT;
            token_start_next = position;
            tok_len_next     = sqll_pkg::LEN_BITS'(1);
          end else if (sqll_pkg::is_alpha(ch) || (ch == "_")) begin
            mode_next        = M_IDENT;
            token_start_next = position;
            tok_len_next     = sqll_pkg::LEN_BITS'(1);
            kw_buf_next      = {{(sqll_pkg::KW_BITS-8){1'b0}}, up_ch};
            too_long_next    = 1'b0;
          end
        end
      endcase
    end

    // End marker returns everything to the reset state
    if (is_end) begin
      mode_next        = M_IDLE;
      position_next    = '0;
      token_start_next = '0;
      kw_buf_next      = '0;
      too_long_next    = 1'b0;
      tok_len_next     = '0;
    end
  end

  // Order the tokens of this item and mark the final one
  always_comb begin
    end_tok           = '0;
    end_tok.kind      = sqll_pkg::KIND_END;
    end_tok.start_pos = position;
    end_tok.length    = '0;

    if (is_end) begin
      a_valid = flush_valid;
      a_tok   = flush_tok;
      b_valid = 1'b1;
      b_tok   = end_tok;
    end else begin
      a_valid = taken ? tk_valid : flush_valid;
      a_tok   = taken ? tk_tok : flush_tok;
      b_valid = !taken && idle_valid;
      b_tok   = idle_tok;
    end

    step = '0;
    if (a_valid && b_valid) begin
      step.count              = 2'd2;
      step.first              = a_tok;
      step.second             = b_tok;
      step.second.last_of_run = 1'b1;
    end else if (a_valid) begin
      step.count             = 2'd1;
      step.first             = a_tok;
      step.first.last_of_run = 1'b1;
    end else if (b_valid) begin
      step.count             = 2'd1;
      step.first             = b_tok;
      step.first.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      position    <= '0;
      token_start <= '0;
      kw_buf      <= '0;
      too_long    <= 1'b0;
      tok_len     <= '0;
    end else if (take) begin
      mode        <= mode_next;
      position    <= position_next;
      token_start <= token_start_next;
      kw_buf      <= kw_buf_next;
      too_long    <= too_long_next;
      tok_len     <= tok_len_next;
    end
  end

endmodule

>>> rtl/core/sqll_out_fifo.sv
// Small token queue: takes up to two tokens per cycle, delivers one.
module sqll_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sqll_pkg::step_t    step,
  output logic               room,
  sqll_out_if.source         tokens
);

  sqll_pkg::token_t               mem [sqll_pkg::FIFO_DEPTH];
  logic [sqll_pkg::PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [sqll_pkg::CNT_BITS-1:0]  count, count_next;
  logic [sqll_pkg::CNT_BITS-1:0]  push_n;
  logic                           pop;

  assign pop    = tokens.valid && tokens.ready;
  assign push_n = push ? sqll_pkg::CNT_BITS'(step.count) : '0;
  assign count_next = count + push_n - sqll_pkg::CNT_BITS'(pop);

  // Room for a worst-case item of two tokens
  assign room = (count <= sqll_pkg::CNT_BITS'(sqll_pkg::FIFO_DEPTH - 2));

  assign tokens.valid       = (count != '0);
  assign tokens.kind        = mem[rd_ptr].kind;
  assign tokens.start_pos   = mem[rd_ptr].start_pos;
  assign tokens.length      = mem[rd_ptr].length;
  assign tokens.last_of_run = mem[rd_ptr].last_of_run;

  // Token storage, no reset needed
  always_ff @(posedge clk) begin
    if (push && (step.count != 2'd0)) begin
      mem[wr_ptr] <= step.first;
    end
    if (push && (step.count == 2'd2)) begin
      mem[wr_ptr + sqll_pkg::PTR_BITS'(1)] <= step.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[sqll_pkg::PTR_BITS-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + sqll_pkg::PTR_BITS'(1);
      end
      count <= count_next;
    end
  end

endmodule

>>> rtl/core/sql_token_lexer.sv
// SQL token lexer: one text byte per cycle in while there is room, completed tokens out.
// A token is registered in the token queue when the byte that completes it is taken.
// Throughput: one byte per cycle while tokens drain; a byte that completes two tokens
// queues both, which leave one at a time, and input ready drops while the four-entry
// token queue has fewer than two free slots.
// Reset: synchronous rst clears the scan state, the position and the token queue.
module sql_token_lexer (
  input  logic        clk,
  input  logic        rst,
  sqll_in_if.sink     text,
  sqll_out_if.source  tokens
);

  logic            room;
  logic            take;
  sqll_pkg::step_t step;

  assign text.ready = room;
  assign take       = text.valid && room;

  sqll_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .ch     (text.ch),
    .is_end (text.is_end),
    .step   (step)
  );

  sqll_out_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (take),
    .step   (step),
    .room   (room),
    .tokens (tokens)
  );

endmodule

>>> bench/tb_sql_token_lexer.sv
// Self-checking bench for the SQL token lexer: directed and random bytes against a token predictor.
module tb_sql_token_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STALL_LIMIT  = 2000;
  localparam int          RANDOM_ITEMS = 730;
  localparam int          HOLD_AT      = 700;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          CALM_FROM    = 1000;
  localparam int          CALM_TO      = 1300;
  localparam int          DRAIN_EVERY  = 150;
  localparam logic [7:0]  QUOTE        = 8'h27;
  localparam logic [7:0]  BACKSLASH    = 8'h5C;

  // Scan state of the predictor
  typedef enum logic [3:0] {
    SM_IDLE, SM_LT, SM_GT, SM_BANG, SM_MINUS, SM_STR, SM_STR_ESC, SM_INT, SM_FRAC, SM_IDENT
  } scan_e;

  typedef struct {
    logic [7:0] ch;
    logic       is_end;
    bit         drain;   // not sent: sender waits here until all tokens have come out
  } text_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sqll_in_if  text_ch ();
  sqll_out_if tok_ch ();

  sql_token_lexer uut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .tokens (tok_ch)
  );

  always #1 clk = ~clk;

  string kw_names [sqll_pkg::KW_COUNT] = '{
    "SELECT", "FROM", "WHERE", "AND", "OR", "NOT", "ORDER", "BY", "ASC",
    "DESC", "JOIN", "ON", "INNER", "LEFT", "INSERT", "INTO", "VALUES",
    "COUNT", "SUM", "AVG", "MIN", "MAX", "AS", "LIMIT", "GROUP", "HAVING",
    "LIKE", "IN", "IS", "NULL", "DISTINCT"
  };
  string op_texts [13] = '{
    "*", ",", ".", "(", ")", "=", ";", "<", ">", "<=", ">=", "<>", "!="
  };

  text_item_t        pending_items[$];
  sqll_pkg::token_t  predicted_tokens[$];
  sqll_pkg::token_t  step_tokens[$];
  int unsigned items_taken = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  int          hold_left = 0;
  bit          held_once = 1'b0;

  // Predictor state
  scan_e       sm;
  logic [15:0] m_pos;
  logic [15:0] m_start;
  logic [7:0]  m_kw [8];
  logic        m_long;
  logic [7:0]  m_len;

  function automatic bit calm_stretch();
    return items_taken >= CALM_FROM && items_taken < CALM_TO;
  endfunction

  // ---------------- token predictor ----------------
  function automatic bit char_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit char_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit char_word(input logic [7:0] c);
    return char_alpha(c) || char_digit(c) || c == "_";
  endfunction

  function automatic bit char_blank(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] up_case(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  // Keyword lookup on the upper-cased prefix buffer
  function automatic sqll_pkg::kind_t ident_kind();
    string w;
    bit    same;
    if (m_long) return sqll_pkg::KIND_IDENT;
    for (int k = 0; k < sqll_pkg::KW_COUNT; k++) begin
      w = kw_names[k];
      if (w.len() == int'(m_len)) begin
        same = 1'b1;
        for (int i = 0; i < w.len(); i++)
          if (m_kw[i] != w[i]) same = 1'b0;
        if (same) return sqll_pkg::KIND_KW0 + sqll_pkg::kind_t'(k);
      end
    end
    return sqll_pkg::KIND_IDENT;
  endfunction

  task automatic reset_scan();
    sm      = SM_IDLE;
    m_pos   = '0;
    m_start = '0;
    m_long  = 1'b0;
    m_len   = '0;
    foreach (m_kw[i]) m_kw[i] = '0;
  endtask

  task automatic add_token(input sqll_pkg::kind_t k, input logic [15:0] st,
                           input logic [7:0] ln);
    sqll_pkg::token_t t;
    t.kind        = k;
    t.start_pos   = st;
    t.length      = ln;
    t.last_of_run = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic start_token(input scan_e md, input logic [15:0] st, input logic [7:0] ln);
    sm      = md;
    m_start = st;
    m_len   = ln;
  endtask

  task automatic bump_len();
    if (m_len < sqll_pkg::MAX_TOKEN_LEN) m_len = m_len + 8'd1;
  endtask

  // Emit whatever token is pending and go idle
  task automatic flush_pending();
    case (sm)
      SM_LT:               add_token(sqll_pkg::KIND_LT, m_start, 8'd1);
      SM_GT:               add_token(sqll_pkg::KIND_GT, m_start, 8'd1);
      SM_BANG, SM_MINUS:   add_token(sqll_pkg::KIND_ERROR, m_start, 8'd1);
      SM_STR, SM_STR_ESC:  add_token(sqll_pkg::KIND_STRING, m_start, m_len);
      SM_INT, SM_FRAC:     add_token(sqll_pkg::KIND_NUMBER, m_start, m_len);
      SM_IDENT:            add_token(ident_kind(), m_start, m_len);
      default: ;
    endcase
    sm = SM_IDLE;
  endtask

  // A byte seen with no token pending
  task automatic lex_idle(input logic [7:0] c, input logic [15:0] p);
    case (c)
      "*":   add_token(sqll_pkg::KIND_STAR, p, 8'd1);
      ",":   add_token(sqll_pkg::KIND_COMMA, p, 8'd1);
      ".":   add_token(sqll_pkg::KIND_DOT, p, 8'd1);
      "(":   add_token(sqll_pkg::KIND_LPAREN, p, 8'd1);
      ")":   add_token(sqll_pkg::KIND_RPAREN, p, 8'd1);
      "=":   add_token(sqll_pkg::KIND_EQ, p, 8'd1);
      ";":   add_token(sqll_pkg::KIND_SEMI, p, 8'd1);
      "<":   start_token(SM_LT, p, 8'd1);
      ">":   start_token(SM_GT, p, 8'd1);
      "!":   start_token(SM_BANG, p, 8'd1);
      "-":   start_token(SM_MINUS, p, 8'd1);
      QUOTE: start_token(SM_STR, p + 16'd1, 8'd0);
      default: begin
        if (char_blank(c)) begin
        end else if (char_digit(c)) begin
          start_token(SM_INT, p, 8'd1);
        end else if (char_alpha(c) || c == "_") begin
          start_token(SM_IDENT, p, 8'd1);
          foreach (m_kw[i]) m_kw[i] = '0;
          m_kw[0] = up_case(c);
          m_long  = 1'b0;
        end else begin
          add_token(sqll_pkg::KIND_ERROR, p, 8'd1);
        end
      end
    endcase
  endtask

  // Work out the tokens one accepted item produces and queue them
  task automatic tokenize_item(input logic [7:0] c, input logic is_end);
    bit          taken;
    logic [15:0] p;
    taken = 1'b0;
    p     = m_pos;
    step_tokens.delete();
    if (is_end) begin
      flush_pending();
      add_token(sqll_pkg::KIND_END, p, 8'd0);
      reset_scan();
    end else begin
      case (sm)
        SM_LT: if (c == ">" || c == "=") begin
          add_token(c == ">" ? sqll_pkg::KIND_NEQ : sqll_pkg::KIND_LTE, m_start, 8'd2);
          sm    = SM_IDLE;
          taken = 1'b1;
        end
        SM_GT: if (c == "=") begin
          add_token(sqll_pkg::KIND_GTE, m_start, 8'd2);
          sm    = SM_IDLE;
          taken = 1'b1;
        end
        SM_BANG: if (c == "=") begin
          add_token(sqll_pkg::KIND_NEQ, m_start, 8'd2);
          sm    = SM_IDLE;
          taken = 1'b1;
        end
        SM_MINUS: if (char_digit(c)) begin
          sm = SM_INT;
          bump_len();
          taken = 1'b1;
        end
        SM_STR: begin
          taken = 1'b1;
          if (c == QUOTE) begin
            add_token(sqll_pkg::KIND_STRING, m_start, m_len);
            sm = SM_IDLE;
          end else begin
            bump_len();
            if (c == BACKSLASH) sm = SM_STR_ESC;
          end
        end
        SM_STR_ESC: begin
          bump_len();
          sm    = SM_STR;
          taken = 1'b1;
        end
        SM_INT: if (char_digit(c) || c == ".") begin
          bump_len();
          if (c == ".") sm = SM_FRAC;
          taken = 1'b1;
        end
        SM_FRAC: if (char_digit(c)) begin
          bump_len();
          taken = 1'b1;
        end
        SM_IDENT: if (char_word(c)) begin
          if (m_len < 8'd8) m_kw[m_len[2:0]] = up_case(c);
          else m_long = 1'b1;
          bump_len();
          taken = 1'b1;
        end
        default: sm = SM_IDLE;
      endcase
      if (!taken) begin
        flush_pending();
        lex_idle(c, p);
      end
      m_pos = m_pos + 16'd1;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    foreach (step_tokens[i]) predicted_tokens.push_back(step_tokens[i]);
  endtask

  // ---------------- stimulus building ----------------
  task automatic push_byte(input logic [7:0] c);
    text_item_t it;
    it.ch     = c;
    it.is_end = 1'b0;
    it.drain  = 1'b0;
    pending_items.push_back(it);
  endtask

  task automatic push_end();
    text_item_t it;
    it.ch     = 8'($urandom_range(0, 255));
    it.is_end = 1'b1;
    it.drain  = 1'b0;
    pending_items.push_back(it);
  endtask

  task automatic push_drain();
    text_item_t it;
    it.ch     = '0;
    it.is_end = 1'b0;
    it.drain  = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_repeat(input logic [7:0] c, input int n);
    for (int i = 0; i < n; i++) push_byte(c);
  endtask

  function automatic logic [7:0] pick_word_char(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  // One random lexeme, mostly well formed, followed by an optional separator
  task automatic push_fragment();
    int         sel;
    int         n;
    string      w;
    logic [7:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      // keyword in random case, sometimes extended into an identifier
      w = kw_names[$urandom_range(0, sqll_pkg::KW_COUNT - 1)];
      for (int i = 0; i < w.len(); i++) begin
        c = w[i];
        if ($urandom_range(0, 1)) c = c + 8'd32;
        push_byte(c);
      end
      if ($urandom_range(0, 7) == 0) push_byte(pick_word_char(1'b0));
    end else if (sel < 45) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      push_byte(pick_word_char(1'b1));
      for (int i = 1; i < n; i++) push_byte(pick_word_char(1'b0));
    end else if (sel < 57) begin
      if ($urandom_range(0, 3) == 0) push_byte("-");
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 1)) begin
        push_byte(".");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(0, 9)));
      end
    end else if (sel < 67) begin
      push_byte(QUOTE);
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          push_byte(BACKSLASH);
          push_byte(8'($urandom_range(0, 255)));
        end else begin
          do c = 8'($urandom_range(32, 126)); while (c == QUOTE || c == BACKSLASH);
          push_byte(c);
        end
      end
      if ($urandom_range(0, 9) != 0) push_byte(QUOTE);
    end else if (sel < 85) begin
      push_text(op_texts[$urandom_range(0, 12)]);
    end else if (sel < 90) begin
      push_byte($urandom_range(0, 1) ? "!" : "-");
    end else if (sel < 96) begin
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_end();
    end
    // separator: one of the six whitespace bytes, or none so tokens abut
    if ($urandom_range(0, 9) < 7) begin
      n = $urandom_range(9, 14);
      push_byte(n == 14 ? " " : 8'(n));
    end
  endtask

  // ---------------- sender ----------------
  always @(negedge clk) begin : drive_text
    text_item_t nxt;
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else if (text_ch.valid && !in_fire) begin
      // item still waiting for ready: hold it
    end else begin
      while (pending_items.size() > 0 && pending_items[0].drain &&
             predicted_tokens.size() == 0)
        void'(pending_items.pop_front());
      if (pending_items.size() > 0 && !pending_items[0].drain &&
          (calm_stretch() || $urandom_range(0, 99) >= 13)) begin
        nxt = pending_items.pop_front();
        text_ch.ch     <= nxt.ch;
        text_ch.is_end <= nxt.is_end;
        text_ch.valid  <= 1'b1;
      end else begin
        text_ch.ch     <= 8'($urandom_range(0, 255));
        text_ch.is_end <= 1'($urandom_range(0, 1));
        text_ch.valid  <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------
  always @(negedge clk) begin
    if (rst) begin
      tok_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      tok_ch.ready <= 1'b0;
    end else if (!held_once && items_taken >= HOLD_AT) begin
      // long hold-off so the token queue fills and input ready drops
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
      tok_ch.ready <= 1'b0;
    end else begin
      tok_ch.ready <= calm_stretch() || $urandom_range(0, 99) >= 13;
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // ---------------- accept, predict, compare, watchdog ----------------
  always @(posedge clk) begin : monitor
    sqll_pkg::token_t want;
    in_fire  = !rst && text_ch.valid && text_ch.ready;
    out_fire = !rst && tok_ch.valid && tok_ch.ready;
    if (in_fire) begin
      tokenize_item(text_ch.ch, text_ch.is_end);
      items_taken++;
    end
    if (out_fire) begin
      if (predicted_tokens.size() == 0) begin
        error_count++;
        $display("%0t: unexpected token: expected none, got kind %0d start %0d",
                 $time, tok_ch.kind, tok_ch.start_pos);
        $display("%0t:   length %0d last %0d", $time, tok_ch.length, tok_ch.last_of_run);
      end else begin
        want = predicted_tokens.pop_front();
        check_field("kind", want.kind, tok_ch.kind);
        check_field("start_pos", want.start_pos, tok_ch.start_pos);
        check_field("length", want.length, tok_ch.length);
        check_field("last_of_run", want.last_of_run, tok_ch.last_of_run);
      end
    end
    if (in_fire || out_fire || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d tokens outstanding",
               $time, STALL_LIMIT, predicted_tokens.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- test sequence ----------------
  initial begin : sequencer
    int base;
    int frags;
    text_ch.valid  = 1'b0;
    text_ch.ch     = '0;
    text_ch.is_end = 1'b0;
    tok_ch.ready   = 1'b0;
    reset_scan();

    // Directed: punctuation, comparisons, lone bang and minus, high byte,
    // trailing dot, escaped quote in an unclosed string, all whitespace
    push_text("*,.()=;<>!=<=>= <!-");
    push_byte(8'hFF);
    push_text("1.'a\\'");
    push_end();
    push_byte(8'h09); push_byte(8'h0A); push_byte(8'h0B);
    push_byte(8'h0C); push_byte(8'h0D);
    push_text("oR");
    push_end();
    push_drain();

    // Random streams
    base  = pending_items.size();
    frags = 0;
    while (pending_items.size() < base + RANDOM_ITEMS) begin
      push_fragment();
      frags++;
      if (frags % DRAIN_EVERY == 0) begin
        push_end();
        push_drain();
      end
    end
    push_end();
    push_drain();

    // Length saturation on identifier, string and number
    push_repeat("q", 300);
    push_byte(" ");
    push_byte(QUOTE);
    push_repeat("x", 300);
    push_byte(QUOTE);
    push_byte("-");
    push_repeat("7", 260);
    push_text(".5 DISTINCT distincts");
    push_end();
    push_drain();

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_items.size() > 0 || text_ch.valid || predicted_tokens.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (predicted_tokens.size() > 0) error_count++;
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/sqll_pkg.sv
rtl/core/sqll_in_if.sv
rtl/core/sqll_out_if.sv
rtl/core/sqll_kw_match.sv
rtl/core/sqll_scan.sv
rtl/core/sqll_out_fifo.sv
rtl/core/sql_token_lexer.sv
bench/tb_sql_token_lexer.sv
